@@ rtl/core/u16u8_pkg.sv @@
// shared types and constants for the utf-16 to utf-8 transcoder
package u16u8_pkg;

   localparam int unsigned RUN_DEPTH = 5;
   localparam int unsigned RUN_IDX_W = $clog2(RUN_DEPTH);
   localparam int unsigned RUN_CNT_W = $clog2(RUN_DEPTH + 1);

   localparam logic [5:0] SURR_TAG_MASK = 6'b111111;
   localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
   localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;
   localparam logic [20:0] SUPP_OFFSET  = 21'h10000;

   typedef enum logic [1:0] {
      STAT_DATA = 2'd0,
      STAT_ERR  = 2'd1,
      STAT_END  = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] out_byte;
      status_type status;
      logic [1:0] unconsumed_count;
   } entry_type;

   typedef struct packed {
      logic [RUN_CNT_W-1:0] cnt;
      entry_type [RUN_DEPTH-1:0] ent;
   } run_type;

endpackage

@@ rtl/core/u16u8_dec.sv @@
// input register, unit pairing, surrogate join and utf-8 encoding
module u16u8_dec
   import u16u8_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_order,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_block,
   input  logic       run_free,
   output run_type    run,
   output logic       run_valid
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eob_ff;

   logic       half_valid_ff, half_valid_in;
   logic [7:0] half_byte_ff, half_byte_in;
   logic       high_valid_ff, high_valid_in;
   logic [9:0] high_bits_ff, high_bits_in;

   logic [15:0] unit;
   logic [20:0] cp;
   logic [2:0]  enc_n;
   logic [7:0]  enc [4];
   logic        do_enc;
   logic        do_err;
   logic [RUN_IDX_W-1:0] body_n;
   logic        take;
   logic        accept;

   assign take      = in_valid_ff && ((run.cnt == '0) || run_free);
   assign run_valid = take && (run.cnt != '0);
   assign req_stall = in_valid_ff && !take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      unit = byte_order ? {half_byte_ff, in_byte_ff} : {in_byte_ff, half_byte_ff};
      half_valid_in = half_valid_ff;
      half_byte_in  = half_byte_ff;
      high_valid_in = high_valid_ff;
      high_bits_in  = high_bits_ff;
      do_enc = 1'b0;
      do_err = 1'b0;
      cp     = {5'd0, unit};
      if (!half_valid_ff) begin
         half_valid_in = 1'b1;
         half_byte_in  = in_byte_ff;
      end else begin
         half_valid_in = 1'b0;
         half_byte_in  = '0;
         if (high_valid_ff) begin
            high_valid_in = 1'b0;
            high_bits_in  = '0;
            if ((unit[15:10] & SURR_TAG_MASK) == LOW_SURR_TAG) begin
               do_enc = 1'b1;
               cp     = {1'b0, high_bits_ff, unit[9:0]} + SUPP_OFFSET;
            end else begin
               do_err = 1'b1;
            end
         end else if ((unit[15:10] & SURR_TAG_MASK) == HIGH_SURR_TAG) begin
            high_valid_in = 1'b1;
            high_bits_in  = unit[9:0];
         end else begin
            do_enc = 1'b1;
         end
      end

      enc[0] = cp[7:0];
      enc[1] = '0;
      enc[2] = '0;
      enc[3] = '0;
      if (cp < 21'h80) begin
         enc_n = 3'd1;
      end else if (cp < 21'h800) begin
         enc_n  = 3'd2;
         enc[0] = {3'b110, cp[10:6]};
         enc[1] = {2'b10, cp[5:0]};
      end else if (cp < 21'h10000) begin
         enc_n  = 3'd3;
         enc[0] = {4'b1110, cp[15:12]};
         enc[1] = {2'b10, cp[11:6]};
         enc[2] = {2'b10, cp[5:0]};
      end else begin
         enc_n  = 3'd4;
         enc[0] = {5'b11110, cp[20:18]};
         enc[1] = {2'b10, cp[17:12]};
         enc[2] = {2'b10, cp[11:6]};
         enc[3] = {2'b10, cp[5:0]};
      end

      run = '0;
      for (int i = 0; i < 4; i++) begin
         run.ent[i].status = STAT_DATA;
         if (do_enc && (3'(i) < enc_n)) begin
            run.ent[i].out_byte = enc[i];
         end
      end
      run.ent[RUN_DEPTH-1].status = STAT_DATA;
      if (do_enc) begin
         body_n = RUN_IDX_W'(enc_n);
      end else if (do_err) begin
         body_n = RUN_IDX_W'(1);
         run.ent[0].status = STAT_ERR;
      end else begin
         body_n = '0;
      end
      run.cnt = RUN_CNT_W'(body_n);
      if (in_eob_ff) begin
         run.ent[body_n].out_byte         = '0;
         run.ent[body_n].status           = STAT_END;
         run.ent[body_n].unconsumed_count = {high_valid_in, half_valid_in};
         run.cnt       = RUN_CNT_W'(body_n) + RUN_CNT_W'(1);
         half_valid_in = 1'b0;
         half_byte_in  = '0;
         high_valid_in = 1'b0;
         high_bits_in  = '0;
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         half_valid_ff <= 1'b0;
         half_byte_ff  <= '0;
         high_valid_ff <= 1'b0;
         high_bits_ff  <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (take) begin
            half_valid_ff <= half_valid_in;
            half_byte_ff  <= half_byte_in;
            high_valid_ff <= high_valid_in;
            high_bits_ff  <= high_bits_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_data_byte;
         in_eob_ff  <= req_end_of_block;
      end
   end

endmodule

@@ rtl/core/u16u8_ser.sv @@
// result run buffer and output register, one result beat per cycle while rsp_stall is low
module u16u8_ser
   import u16u8_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  run_type    run,
   input  logic       run_valid,
   output logic       run_free,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_status,
   output logic [1:0] rsp_unconsumed_count,
   output logic       rsp_last_of_run
);

   run_type              run_ff;
   logic                 run_valid_ff, run_valid_in;
   logic [RUN_IDX_W-1:0] idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   entry_type            rsp_ent_ff;
   logic                 rsp_last_ff;
   logic                 rsp_load;
   logic                 run_last;

   assign rsp_load = run_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign run_last = (RUN_CNT_W'(idx_ff) + RUN_CNT_W'(1)) == run_ff.cnt;
   assign run_free = !run_valid_ff || (rsp_load && run_last);

   always_comb begin
      run_valid_in = run_valid_ff;
      idx_in       = idx_ff;
      if (run_valid) begin
         run_valid_in = 1'b1;
         idx_in       = '0;
      end else if (rsp_load && run_last) begin
         run_valid_in = 1'b0;
         idx_in       = '0;
      end else if (rsp_load) begin
         idx_in = idx_ff + RUN_IDX_W'(1);
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_valid_ff <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_valid_ff <= run_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (run_valid) begin
         run_ff <= run;
      end
      if (rsp_load) begin
         rsp_ent_ff  <= run_ff.ent[idx_ff];
         rsp_last_ff <= run_last;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_out_byte         = rsp_ent_ff.out_byte;
   assign rsp_status           = rsp_ent_ff.status;
   assign rsp_unconsumed_count = rsp_ent_ff.unconsumed_count;
   assign rsp_last_of_run      = rsp_last_ff;

endmodule

@@ rtl/core/utf16_to_utf8_transcoder_core.sv @@
// top level of the utf-16 to utf-8 transcoder
//
// req channel: one utf-16 byte per beat with an end_of_block flag. rsp channel:
// one result per beat, a utf-8 byte (status 0), a bad surrogate pair (status 1)
// or an end record (status 2) carrying the count of unconverted trailing bytes;
// rsp_last_of_run marks the final result caused by one input byte.
// csr channel: one write beat sets byte_order (0 little-endian, 1 big-endian);
// csr_ready is always high; writes must be made while the block is idle (not enforced).
// a byte passes the input register, run buffer and result register in turn.
// throughput: while rsp_stall is low the result register moves one beat per
// cycle, and a byte's results (one to five) leave one beat at a time; bytes
// that cause no result go through at one per cycle. the run buffer sits
// between the decode stage and the result register.
// reset clears all pending unit and surrogate state and sets byte_order to 0.
// while rsp_stall is high the result beat holds; the run buffer and the input
// register fill and then req_stall rises.
module utf16_to_utf8_transcoder_core
   import u16u8_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_byte_order,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_block,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_status,
   output logic [1:0] rsp_unconsumed_count,
   output logic       rsp_last_of_run
);

   logic    byte_order_ff;
   run_type run;
   logic    run_valid;
   logic    run_free;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_order_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         byte_order_ff <= csr_byte_order;
      end
   end

   u16u8_dec u_dec (
      .clock            (clock),
      .reset            (reset),
      .byte_order       (byte_order_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_end_of_block (req_end_of_block),
      .run_free         (run_free),
      .run              (run),
      .run_valid        (run_valid)
   );

   u16u8_ser u_ser (
      .clock                (clock),
      .reset                (reset),
      .run                  (run),
      .run_valid            (run_valid),
      .run_free             (run_free),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_status           (rsp_status),
      .rsp_unconsumed_count (rsp_unconsumed_count),
      .rsp_last_of_run      (rsp_last_of_run)
   );

endmodule

@@ rtl/core/u16u8_chk.sv @@
// port-level checker for the transcoder, bound to the top level
module u16u8_chk
   import u16u8_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic [1:0] rsp_status,
   input logic [1:0] rsp_unconsumed_count,
   input logic       rsp_last_of_run
);

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_status) && $stable(rsp_last_of_run))
      else $error("stalled rsp beat changed");

   a_end_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_END) |-> rsp_last_of_run)
      else $error("end record not last of run");

   a_count_only_end : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_END) |-> rsp_unconsumed_count == 2'd0)
      else $error("unconsumed count outside end record");

   a_no_byte_on_status : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_DATA) |-> rsp_out_byte == 8'd0)
      else $error("byte on non-data result");

   a_err_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && (rsp_status == STAT_ERR) && !rsp_last_of_run
         |=> rsp_valid && (rsp_status == STAT_END))
      else $error("error not followed by end record");

endmodule

bind utf16_to_utf8_transcoder_core u16u8_chk u_chk (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_out_byte         (rsp_out_byte),
   .rsp_status           (rsp_status),
   .rsp_unconsumed_count (rsp_unconsumed_count),
   .rsp_last_of_run      (rsp_last_of_run)
);
